// ===== rtl/rdc_pkg.sv =====
// shared constants, types and helpers for the radix digit converter
`timescale 1ns / 1ps

package rdc_pkg;

   localparam int MAX_DIGITS_DEF = 64;
   localparam int VALUE_BITS_DEF = 64;

   localparam int RADIX_W = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 8;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 5;
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] REG_RADIX       = 3'd0;
   localparam logic [IDX_W-1:0] REG_CHARS_0_3   = 3'd1;
   localparam logic [IDX_W-1:0] REG_CHARS_4_7   = 3'd2;
   localparam logic [IDX_W-1:0] REG_CHARS_8_11  = 3'd3;
   localparam logic [IDX_W-1:0] REG_CHARS_12_15 = 3'd4;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   localparam logic [CSR_W-1:0] CHARS_0_3_RESET   = 32'h3332_3130;
   localparam logic [CSR_W-1:0] CHARS_4_7_RESET   = 32'h3736_3534;
   localparam logic [CSR_W-1:0] CHARS_8_11_RESET  = 32'h6261_3938;
   localparam logic [CSR_W-1:0] CHARS_12_15_RESET = 32'h6665_6463;

   typedef logic [3:0][CSR_W-1:0] char_table_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_WAIT = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   // picks byte d of the sixteen-byte character table
   function automatic logic [CHAR_W-1:0] char_of(input char_table_type tbl,
                                                 input logic [DIGIT_W-1:0] d);
      logic [CSR_W-1:0] word;
      word = tbl[d[3:2]];
      return word[{d[1:0], 3'b000} +: CHAR_W];
   endfunction

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

endpackage

// ===== rtl/rdc_divider.sv =====
// iterative restoring divider, one quotient bit per cycle, small divisor
`timescale 1ns / 1ps

module rdc_divider #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [VALUE_BITS-1:0]         dividend,
   input  logic [rdc_pkg::RADIX_W-1:0]   divisor,
   output logic                          done,
   output logic [VALUE_BITS-1:0]         quotient,
   output logic [rdc_pkg::DIGIT_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_BITS);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]       quot_ff, quot_in;
   logic [rdc_pkg::RADIX_W-1:0] rem_ff, rem_in;
   logic [rdc_pkg::RADIX_W-1:0] div_ff, div_in;
   logic [rdc_pkg::RADIX_W:0]   partial;
   logic                        ge;

   // partial remainder stays below the divisor, so it fits after the shift
   assign partial = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign ge      = (partial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_LOAD;
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], ge};
         rem_in  = ge ? rdc_pkg::RADIX_W'(partial - {1'b0, div_ff})
                      : partial[rdc_pkg::RADIX_W-1:0];
         cnt_in  = cnt_ff - CNT_ONE;
         if (cnt_ff == CNT_ONE) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff[rdc_pkg::DIGIT_W-1:0];

endmodule

// ===== rtl/rdc_digit_store.sv =====
// digit memory, one write port and one registered read port
`timescale 1ns / 1ps

module rdc_digit_store #(
   parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_DIGITS)-1:0]     wr_addr,
   input  logic [rdc_pkg::DIGIT_W-1:0]       wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(MAX_DIGITS)-1:0]     rd_addr,
   output logic [rdc_pkg::DIGIT_W-1:0]       rd_data
);

   logic [rdc_pkg::DIGIT_W-1:0] mem_ff [MAX_DIGITS];
   logic [rdc_pkg::DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         // a digit written in the same cycle is passed straight through
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/radix_digit_converter_core.sv =====
// radix digit converter top level: register port, sequencer and output stage
`timescale 1ns / 1ps

//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  request   req_value                               start high while busy low
//  result    rsp_digit_char, rsp_last_digit          rsp_strobe, one cycle, no stall
//  csr       psel penable pwrite paddr pwdata prdata write in the access cycle
//
//  each digit passes through the shared shift-subtract divider (a start pulse, the
//  quotient bits one after another, then a done pulse); digits leave one per cycle
//  busy stays high from the accepted start until the last digit is issued
//  reset is synchronous and active high; no clearing pass, memory is written before read
//  the receiver cannot stall, each result word is shown for exactly one cycle

module radix_digit_converter_core #(
   parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [63:0]                   req_value,
   output logic                          rsp_strobe,
   output logic [rdc_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last_digit,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rdc_pkg::ADDR_W-1:0]    paddr,
   input  logic [rdc_pkg::CSR_W-1:0]     pwdata,
   output logic [rdc_pkg::CSR_W-1:0]     prdata,
   output logic                          pready
);

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int MADR_W = $clog2(MAX_DIGITS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

   // configuration registers
   logic [rdc_pkg::RADIX_W-1:0]  radix_ff;
   rdc_pkg::char_table_type      chars_ff;
   logic                         csr_we;
   logic [rdc_pkg::IDX_W-1:0]    csr_idx;
   logic [rdc_pkg::RADIX_W-1:0]  eff_radix;

   // sequencer
   rdc_pkg::state_type           state_ff, state_in;
   logic [VALUE_BITS-1:0]        remaining_ff, remaining_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [MADR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic                         last_pend_ff, last_pend_in;
   logic [CNT_W-1:0]             count_m1, count_m2;

   // output stage
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [rdc_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;

   // divider and store hookup
   logic                         div_start;
   logic                         div_done;
   logic [VALUE_BITS-1:0]        div_quot;
   logic [rdc_pkg::DIGIT_W-1:0]  div_rem;
   logic                         st_wr_en;
   logic                         st_rd_en;
   logic [MADR_W-1:0]            st_rd_addr;
   logic [rdc_pkg::DIGIT_W-1:0]  st_rd_data;

   assign pready  = 1'b1;
   assign csr_we  = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= rdc_pkg::RADIX_RESET;
         chars_ff[0] <= rdc_pkg::CHARS_0_3_RESET;
         chars_ff[1] <= rdc_pkg::CHARS_4_7_RESET;
         chars_ff[2] <= rdc_pkg::CHARS_8_11_RESET;
         chars_ff[3] <= rdc_pkg::CHARS_12_15_RESET;
      end else if (csr_we) begin
         unique case (csr_idx)
            rdc_pkg::REG_RADIX: begin
               radix_ff <= pwdata[rdc_pkg::RADIX_W-1:0];
            end
            rdc_pkg::REG_CHARS_0_3: begin
               chars_ff[0] <= pwdata;
            end
            rdc_pkg::REG_CHARS_4_7: begin
               chars_ff[1] <= pwdata;
            end
            rdc_pkg::REG_CHARS_8_11: begin
               chars_ff[2] <= pwdata;
            end
            rdc_pkg::REG_CHARS_12_15: begin
               chars_ff[3] <= pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rdc_pkg::REG_RADIX:       prdata = {{(rdc_pkg::CSR_W-rdc_pkg::RADIX_W){1'b0}},
                                             radix_ff};
         rdc_pkg::REG_CHARS_0_3:   prdata = chars_ff[0];
         rdc_pkg::REG_CHARS_4_7:   prdata = chars_ff[1];
         rdc_pkg::REG_CHARS_8_11:  prdata = chars_ff[2];
         rdc_pkg::REG_CHARS_12_15: prdata = chars_ff[3];
         default:                  prdata = '0;
      endcase
   end

   assign eff_radix = rdc_pkg::clamp_radix(radix_ff);

   assign count_m1 = count_ff - CNT_ONE;
   assign count_m2 = count_ff - CNT_TWO;

   assign busy      = (state_ff != rdc_pkg::S_IDLE);
   assign div_start = (state_ff == rdc_pkg::S_DIV);
   // digits past the store depth are the high ones and get dropped
   assign st_wr_en  = (state_ff == rdc_pkg::S_WAIT) && div_done && (count_ff != CNT_MAX);

   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      last_pend_in = last_pend_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = rsp_last_ff;
      rsp_char_in  = rsp_char_ff;
      st_rd_en     = 1'b0;
      st_rd_addr   = rd_ptr_ff;
      unique case (state_ff)
         rdc_pkg::S_IDLE: begin
            if (start) begin
               remaining_in = req_value[VALUE_BITS-1:0];
               count_in     = '0;
               state_in     = rdc_pkg::S_DIV;
            end
         end
         rdc_pkg::S_DIV: begin
            state_in = rdc_pkg::S_WAIT;
         end
         rdc_pkg::S_WAIT: begin
            if (div_done) begin
               remaining_in = div_quot;
               if (st_wr_en) begin
                  count_in = count_ff + CNT_ONE;
               end
               if (div_quot == '0) begin
                  // first read goes out here, data arrives in the emit state
                  st_rd_en     = 1'b1;
                  st_rd_addr   = st_wr_en ? count_ff[MADR_W-1:0] : count_m1[MADR_W-1:0];
                  last_pend_in = st_wr_en ? (count_ff == '0) : (count_ff == CNT_ONE);
                  rd_ptr_in    = st_wr_en ? count_m1[MADR_W-1:0] : count_m2[MADR_W-1:0];
                  state_in     = rdc_pkg::S_EMIT;
               end else begin
                  state_in = rdc_pkg::S_DIV;
               end
            end
         end
         rdc_pkg::S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = last_pend_ff;
            rsp_char_in  = rdc_pkg::char_of(chars_ff, st_rd_data);
            if (last_pend_ff) begin
               state_in = rdc_pkg::S_IDLE;
            end else begin
               st_rd_en     = 1'b1;
               st_rd_addr   = rd_ptr_ff;
               last_pend_in = (rd_ptr_ff == '0);
               rd_ptr_in    = rd_ptr_ff - MADR_W'(1);
            end
         end
         default: begin
            state_in = rdc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdc_pkg::S_IDLE;
         count_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
         last_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
         last_pend_ff <= last_pend_in;
      end
      rd_ptr_ff   <= rd_ptr_in;
      rsp_last_ff <= rsp_last_in;
      rsp_char_ff <= rsp_char_in;
   end

   rdc_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (remaining_ff),
      .divisor   (eff_radix),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   rdc_digit_store #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (count_ff[MADR_W-1:0]),
      .wr_data (div_rem),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == rdc_pkg::S_EMIT))
      else $error("result word without emit state");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == rdc_pkg::S_WAIT))
      else $error("divider finished outside wait state");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ({1'b0, div_rem} < eff_radix))
      else $error("remainder not below radix");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("digit count past store depth");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

endmodule

// ===== tb/sv/digit_checker.sv =====
// checker for the radix digit converter: tracks registers, predicts digit words, compares
`timescale 1ns / 1ps

module digit_checker #(
   parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [63:0]                 req_value,
   input  logic                        rsp_strobe,
   input  logic [rdc_pkg::CHAR_W-1:0]  rsp_digit_char,
   input  logic                        rsp_last_digit,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rdc_pkg::ADDR_W-1:0]  paddr,
   input  logic [rdc_pkg::CSR_W-1:0]   pwdata,
   input  logic [rdc_pkg::CSR_W-1:0]   prdata,
   input  logic                        pready,
   output int                          fail_count,
   output int                          pending
);

   typedef struct packed {
      logic [rdc_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } digit_word_type;

   logic [rdc_pkg::RADIX_W-1:0] radix_reg;
   logic [rdc_pkg::CSR_W-1:0]   char_regs [0:3];
   digit_word_type              digit_queue [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < 40) begin
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      end
      fail_count++;
   endtask

   // digits found low first by repeated division, queued high first
   task automatic expect_digits(input logic [63:0] value);
      logic [63:0]                 rem;
      logic [63:0]                 base;
      logic [rdc_pkg::RADIX_W-1:0] r;
      logic [rdc_pkg::DIGIT_W-1:0] digs [0:63];
      logic [rdc_pkg::DIGIT_W-1:0] d;
      logic [rdc_pkg::CSR_W-1:0]   tword;
      digit_word_type              w;
      int                          n;
      int                          lim;
      r = radix_reg;
      if (r < 5'd2) begin
         r = 5'd2;
      end else if (r > 5'd16) begin
         r = 5'd16;
      end
      base = 64'(r);
      lim  = (MAX_DIGITS > 64) ? 64 : MAX_DIGITS;
      rem  = value;
      if (VALUE_BITS < 64) begin
         rem = value & ((64'd1 << VALUE_BITS) - 64'd1);
      end
      n = 0;
      do begin
         if (n < lim) begin
            digs[n] = rdc_pkg::DIGIT_W'(rem % base);
            n++;
         end
         rem = rem / base;
      end while (rem != 64'd0);
      for (int k = 0; k < n; k++) begin
         d      = digs[n - 1 - k];
         tword  = char_regs[d[3:2]];
         w.ch   = rdc_pkg::CHAR_W'(tword >> (8 * d[1:0]));
         w.last = (k == n - 1);
         digit_queue.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      digit_word_type              w;
      logic [rdc_pkg::IDX_W-1:0]   idx;
      logic [rdc_pkg::CSR_W-1:0]   want;
      logic                        known;
      idx = paddr[rdc_pkg::ADDR_W-1:2];
      if (reset) begin
         radix_reg    = rdc_pkg::RADIX_RESET;
         char_regs[0] = rdc_pkg::CHARS_0_3_RESET;
         char_regs[1] = rdc_pkg::CHARS_4_7_RESET;
         char_regs[2] = rdc_pkg::CHARS_8_11_RESET;
         char_regs[3] = rdc_pkg::CHARS_12_15_RESET;
         digit_queue.delete();
      end else begin
         if (rsp_strobe) begin
            if (digit_queue.size() == 0) begin
               report_mismatch("unexpected word", {55'd0, rsp_digit_char, rsp_last_digit},
                               64'd0);
            end else begin
               w = digit_queue.pop_front();
               if (rsp_digit_char !== w.ch) begin
                  report_mismatch("digit_char", 64'(rsp_digit_char), 64'(w.ch));
               end
               if (rsp_last_digit !== w.last) begin
                  report_mismatch("last_digit", 64'(rsp_last_digit), 64'(w.last));
               end
            end
         end
         if (psel && penable && pready && !pwrite) begin
            known = 1'b1;
            want  = '0;
            case (idx)
               rdc_pkg::REG_RADIX:       want = rdc_pkg::CSR_W'(radix_reg);
               rdc_pkg::REG_CHARS_0_3:   want = char_regs[0];
               rdc_pkg::REG_CHARS_4_7:   want = char_regs[1];
               rdc_pkg::REG_CHARS_8_11:  want = char_regs[2];
               rdc_pkg::REG_CHARS_12_15: want = char_regs[3];
               default:                  known = 1'b0;
            endcase
            if (known && prdata !== want) begin
               report_mismatch("register read", 64'(prdata), 64'(want));
            end
         end
         if (psel && penable && pready && pwrite) begin
            case (idx)
               rdc_pkg::REG_RADIX:       radix_reg    = pwdata[rdc_pkg::RADIX_W-1:0];
               rdc_pkg::REG_CHARS_0_3:   char_regs[0] = pwdata;
               rdc_pkg::REG_CHARS_4_7:   char_regs[1] = pwdata;
               rdc_pkg::REG_CHARS_8_11:  char_regs[2] = pwdata;
               rdc_pkg::REG_CHARS_12_15: char_regs[3] = pwdata;
               default:                  ;
            endcase
         end
         if (start && !busy) begin
            expect_digits(req_value);
         end
      end
      pending = digit_queue.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the radix digit converter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

   localparam int          MAX_DIGITS   = 64;
   localparam int          VALUE_BITS   = 64;
   localparam longint      CYCLE_LIMIT  = 8_000_000;
   localparam logic [rdc_pkg::IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [63:0]                  req_value;
   logic                         rsp_strobe;
   logic [rdc_pkg::CHAR_W-1:0]   rsp_digit_char;
   logic                         rsp_last_digit;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [rdc_pkg::ADDR_W-1:0]   paddr;
   logic [rdc_pkg::CSR_W-1:0]    pwdata;
   logic [rdc_pkg::CSR_W-1:0]    prdata;
   logic                         pready;
   int                           fail_count;
   int                           pending;
   longint                       cycle_count;
   logic [rdc_pkg::RADIX_W-1:0]  cur_radix;

   radix_digit_converter_core #(
      .MAX_DIGITS(MAX_DIGITS),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value(req_value), .rsp_strobe(rsp_strobe),
      .rsp_digit_char(rsp_digit_char), .rsp_last_digit(rsp_last_digit),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   digit_checker #(
      .MAX_DIGITS(MAX_DIGITS),
      .VALUE_BITS(VALUE_BITS)
   ) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value(req_value), .rsp_strobe(rsp_strobe),
      .rsp_digit_char(rsp_digit_char), .rsp_last_digit(rsp_last_digit),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 60);
   endfunction

   // powers of the base and one below them sit on digit count boundaries
   function automatic logic [63:0] boundary_value(input logic [rdc_pkg::RADIX_W-1:0] r_in);
      logic [63:0] base;
      logic [63:0] p;
      int          k;
      base = (r_in < 5'd2) ? 64'd2 : (r_in > 5'd16) ? 64'd16 : 64'(r_in);
      p = 64'd1;
      k = $urandom_range(0, 64);
      for (int i = 0; i < k; i++) begin
         if (p <= ALL_ONES / base) begin
            p = p * base;
         end
      end
      return ($urandom_range(0, 1) == 1) ? p - 64'd1 : p;
   endfunction

   function automatic logic [63:0] random_value();
      int          sel;
      int          w;
      logic [63:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
         v = 64'd0;
      end else if (sel < 18) begin
         v = boundary_value(cur_radix);
      end else if (sel < 24) begin
         v = (sel < 21) ? ALL_ONES : (TOP_BIT | rand64());
      end else begin
         w = $urandom_range(1, 64);
         v = rand64();
         if (w < 64) begin
            v = v & ((64'd1 << w) - 64'd1);
         end
         v[w-1] = 1'b1;
      end
      return v;
   endfunction

   // word goes in at the edge where start is high and busy low
   task automatic send_value(input logic [63:0] v);
      start     <= 1'b1;
      req_value <= v;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(input logic [rdc_pkg::IDX_W-1:0] idx, input logic wr,
                             input logic [rdc_pkg::CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back_all();
      csr_access(rdc_pkg::REG_RADIX, 1'b0, '0);
      csr_access(rdc_pkg::REG_CHARS_0_3, 1'b0, '0);
      csr_access(rdc_pkg::REG_CHARS_4_7, 1'b0, '0);
      csr_access(rdc_pkg::REG_CHARS_8_11, 1'b0, '0);
      csr_access(rdc_pkg::REG_CHARS_12_15, 1'b0, '0);
   endtask

   task automatic apply_setting(input logic [rdc_pkg::RADIX_W-1:0] r,
                                input logic [rdc_pkg::CSR_W-1:0] t0,
                                input logic [rdc_pkg::CSR_W-1:0] t1,
                                input logic [rdc_pkg::CSR_W-1:0] t2,
                                input logic [rdc_pkg::CSR_W-1:0] t3);
      wait_drained();
      csr_access(rdc_pkg::REG_RADIX, 1'b1,
                 {$urandom} & ~rdc_pkg::CSR_W'(5'h1F) | rdc_pkg::CSR_W'(r));
      csr_access(rdc_pkg::REG_CHARS_0_3, 1'b1, t0);
      csr_access(rdc_pkg::REG_CHARS_4_7, 1'b1, t1);
      csr_access(rdc_pkg::REG_CHARS_8_11, 1'b1, t2);
      csr_access(rdc_pkg::REG_CHARS_12_15, 1'b1, t3);
      // writes past the register list must be dropped
      csr_access(REG_UNUSED_FIRST + rdc_pkg::IDX_W'($urandom_range(0, 2)), 1'b1, $urandom);
      read_back_all();
      cur_radix = r;
   endtask

   initial begin
      logic [rdc_pkg::RADIX_W-1:0] phase_radix [0:9];
      logic [rdc_pkg::CSR_W-1:0]   t [0:3];
      logic                        quiet;
      start     <= 1'b0;
      req_value <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      reset     <= 1'b1;
      cur_radix = rdc_pkg::RADIX_RESET;
      phase_radix = '{5'd2, 5'd16, 5'd7, 5'd3, 5'd0, 5'd31, 5'd12, 5'd5, 5'd1, 5'd17};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back_all();

      // decimal with the reset table
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'd9);
      idle_for(3);
      send_value(64'd10);
      send_value(64'd99);
      send_value(64'd100);
      send_value(ALL_ONES);
      idle_for(1);
      send_value(64'd10000000000000000000);
      send_value(64'd9999999999999999999);
      send_value(TOP_BIT);
      send_value(64'h5555_5555_5555_5555);
      send_value(64'hAAAA_AAAA_AAAA_AAAA);

      // binary gives the longest runs
      apply_setting(5'd2, rdc_pkg::CHARS_0_3_RESET, rdc_pkg::CHARS_4_7_RESET,
                    rdc_pkg::CHARS_8_11_RESET, rdc_pkg::CHARS_12_15_RESET);
      send_value(64'd0);
      send_value(64'd1);
      send_value(ALL_ONES);
      send_value(TOP_BIT);

      // hex touches every table byte
      apply_setting(5'd16, 32'h4443_4241, 32'h4847_4645, 32'h4C4B_4A49, 32'h504F_4E4D);
      send_value(64'hFEDC_BA98_7654_3210);
      send_value(64'h0123_4567_89AB_CDEF);
      send_value(ALL_ONES);

      // out of range bases clamp to two and sixteen
      apply_setting(5'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_value(64'd5);
      apply_setting(5'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_value(64'd6);
      apply_setting(5'd31, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_value(64'hABC);
      apply_setting(5'd17, $urandom, $urandom, $urandom, $urandom);
      send_value(64'd255);

      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 4)
            0: t = '{rdc_pkg::CHARS_0_3_RESET, rdc_pkg::CHARS_4_7_RESET,
                     rdc_pkg::CHARS_8_11_RESET, rdc_pkg::CHARS_12_15_RESET};
            1: t = '{$urandom, $urandom, $urandom, $urandom};
            2: t = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
            default: t = '{$urandom, $urandom, $urandom, $urandom};
         endcase
         apply_setting((ph >= 8) ? 5'($urandom_range(0, 31)) : phase_radix[ph],
                       t[0], t[1], t[2], t[3]);
         quiet = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < 44; i++) begin
            send_value(random_value());
            if (!quiet) begin
               idle_for(gap_len());
            end
         end
      end

      // back to the reset setting at the end
      apply_setting(rdc_pkg::RADIX_RESET, rdc_pkg::CHARS_0_3_RESET, rdc_pkg::CHARS_4_7_RESET,
                    rdc_pkg::CHARS_8_11_RESET, rdc_pkg::CHARS_12_15_RESET);
      send_value(random_value());
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rdc_pkg.sv
rtl/rdc_divider.sv
rtl/rdc_digit_store.sv
rtl/radix_digit_converter_core.sv
tb/sv/digit_checker.sv
tb/sv/testbench.sv
